>>> rtl/core/fwt_pkg.sv
// ----------------------------------------------------------------------------
// fwt_pkg
// Types, field widths and status codes shared by the futex waiter table.
// ----------------------------------------------------------------------------
package fwt_pkg;

  localparam int SLOTS       = 64;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int ADDR_W      = 48;
  localparam int WORD_W      = 64;
  localparam int ID_W        = 8;
  localparam int TMO_W       = 32;
  localparam int TIME_W      = 64;

  localparam logic [1:0] OP_WAIT = 2'd0;
  localparam logic [1:0] OP_WAKE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_WOKEN    = 3'd1;
  localparam logic [2:0] ST_TIMEDOUT = 3'd2;
  localparam logic [2:0] ST_CHANGED  = 3'd3;
  localparam logic [2:0] ST_NOSLOT   = 3'd4;
  localparam logic [2:0] ST_INVALID  = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;

  // scan mode of the head unit
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_WAIT   = 2'd1;
  localparam logic [1:0] MODE_WAKE   = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word_value;
    logic [WORD_W-1:0] count_or_expected;
    logic [ID_W-1:0]   waiter_id;
    logic [TMO_W-1:0]  timeout_ticks;
  } item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ID_W-1:0]  who;
    logic [CNT_W-1:0] woken_so_far;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   waiter;
    logic [TIME_W-1:0] deadline;
  } slot_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   wid;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  cnt_lo;
    logic              cnt_hi_nz;
    logic              placed;
  } head_ctl_t;

endpackage

>>> rtl/core/fwt_cell.sv
// ----------------------------------------------------------------------------
// fwt_cell
// One waiter slot of the ring; takes its neighbor's slot on each shift.
// ----------------------------------------------------------------------------
module fwt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  fwt_pkg::slot_t d,
  output fwt_pkg::slot_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

>>> rtl/core/fwt_head.sv
// ----------------------------------------------------------------------------
// fwt_head
// Examines the slot at the head of the ring and decides queue, wake or
// timeout for it; returns the updated slot and a result when one is due.
// ----------------------------------------------------------------------------
module fwt_head (
  input  fwt_pkg::slot_t    entry,
  input  fwt_pkg::head_ctl_t ctl,
  output fwt_pkg::slot_t    entry_out,
  output logic              hit,
  output fwt_pkg::result_t  res
);

  logic free;
  logic below_cap;
  logic below_cnt;

  always_comb begin
    free      = (entry.addr == '0);
    below_cap = (ctl.n < fwt_pkg::CNT_W'(fwt_pkg::MAX_RESULTS));
    below_cnt = ctl.cnt_hi_nz || (ctl.n < ctl.cnt_lo);
    hit       = 1'b0;
    entry_out = entry;
    res       = '0;
    case (ctl.mode)
      fwt_pkg::MODE_WAIT: begin
        if (free && !ctl.placed) begin
          hit                = 1'b1;
          entry_out.addr     = ctl.addr;
          entry_out.waiter   = ctl.wid;
          entry_out.deadline = ctl.deadline;
          res.status         = fwt_pkg::ST_QUEUED;
          res.who            = ctl.wid;
        end
      end
      fwt_pkg::MODE_WAKE: begin
        if (!free && entry.addr == ctl.addr && below_cap && below_cnt) begin
          hit              = 1'b1;
          entry_out        = '0;
          res.status       = fwt_pkg::ST_WOKEN;
          res.who          = entry.waiter;
          res.woken_so_far = ctl.n + 1'b1;
        end
      end
      fwt_pkg::MODE_TICK: begin
        if (!free && entry.deadline != '0 && ctl.now >= entry.deadline && below_cap) begin
          hit        = 1'b1;
          entry_out  = '0;
          res.status = fwt_pkg::ST_TIMEDOUT;
          res.who    = entry.waiter;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/futex_waiter_table_top.sv
// ----------------------------------------------------------------------------
// futex_waiter_table_top
// Futex waiter table: wait, wake and tick items over a ring of waiter slots.
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_stall carries wait, wake and tick
// requests; output channel result/result_valid/result_stall carries the
// result items, the final one of each request marked by last.
// The slots sit in a ring of cells that rotates by one position per scan
// step past a single head unit, so slot order is the order in which slots
// reach the head. Each request makes one full rotation: the item is taken,
// the ring makes 64 scan steps, then the finish state follows. Results
// leave through a one-deep hold register and an output register; each
// result waits in the hold register until the next hit or the finish state.
// item_stall is high while a request is being worked on.
// A stalled receiver holds the output register; the ring stops only when
// the head finds another result while one is already held, and resumes
// once the output drains; nothing is lost.
// Synchronous reset frees every slot, clears time to zero and empties
// the output.
// ----------------------------------------------------------------------------
module futex_waiter_table_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  fwt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output fwt_pkg::result_t result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                   state;
  logic [fwt_pkg::SLOT_W-1:0]   step;
  fwt_pkg::head_ctl_t           ctl;
  logic [2:0]                   fin_status;
  logic                         pend_valid;
  fwt_pkg::result_t             pend;

  fwt_pkg::slot_t               ring_q [fwt_pkg::SLOTS];
  fwt_pkg::slot_t               head_out;
  logic                         hit;
  fwt_pkg::result_t             head_res;
  logic                         shift;

  logic                         accept;
  logic                         out_free;
  logic                         out_load;
  fwt_pkg::result_t             out_data;
  logic                         fin_go;
  logic [fwt_pkg::TIME_W:0]     dl_sum;
  logic [fwt_pkg::TIME_W-1:0]   dl;

  fwt_head u_head (
    .entry     (ring_q[0]),
    .ctl       (ctl),
    .entry_out (head_out),
    .hit       (hit),
    .res       (head_res)
  );

  for (genvar k = 0; k < fwt_pkg::SLOTS; k++) begin : g_ring
    fwt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     ((k == fwt_pkg::SLOTS - 1) ? head_out : ring_q[(k + 1) % fwt_pkg::SLOTS]),
      .q     (ring_q[k])
    );
  end

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    dl_sum = {1'b0, ctl.now} + {{(fwt_pkg::TIME_W + 1 - fwt_pkg::TMO_W){1'b0}},
                                item.timeout_ticks};
    if (item.timeout_ticks == '0) begin
      dl = '0;
    end else if (dl_sum[fwt_pkg::TIME_W]) begin
      dl = '1;
    end else begin
      dl = dl_sum[fwt_pkg::TIME_W-1:0];
    end
  end

  always_comb begin
    shift    = 1'b0;
    out_load = 1'b0;
    out_data = pend;
    fin_go   = 1'b0;
    case (state)
      S_SCAN: begin
        shift    = !(hit && pend_valid && !out_free);
        out_load = shift && hit && pend_valid;
      end
      S_FIN: begin
        if (pend_valid) begin
          fin_go        = out_free;
          out_load      = out_free;
          out_data.last = 1'b1;
        end else if (ctl.mode == fwt_pkg::MODE_TICK) begin
          fin_go = 1'b1;
        end else begin
          fin_go   = out_free;
          out_load = out_free;
          out_data = '{status: fin_status, who: '0, woken_so_far: '0, last: 1'b1};
        end
      end
      default: begin
        shift = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      ctl.now      <= '0;
      ctl.mode     <= fwt_pkg::MODE_SINGLE;
      ctl.n        <= '0;
      ctl.placed   <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state         <= S_SCAN;
            step          <= '0;
            ctl.n         <= '0;
            ctl.placed    <= 1'b0;
            ctl.addr      <= item.addr;
            ctl.wid       <= item.waiter_id;
            ctl.deadline  <= dl;
            ctl.cnt_lo    <= item.count_or_expected[fwt_pkg::CNT_W-1:0];
            ctl.cnt_hi_nz <= |item.count_or_expected[fwt_pkg::WORD_W-1:fwt_pkg::CNT_W];
            pend_valid    <= 1'b0;
            fin_status    <= fwt_pkg::ST_INVALID;
            ctl.mode      <= fwt_pkg::MODE_SINGLE;
            case (item.op)
              fwt_pkg::OP_WAIT: begin
                if (item.addr == '0) begin
                  fin_status <= fwt_pkg::ST_INVALID;
                end else if (item.word_value != item.count_or_expected) begin
                  fin_status <= fwt_pkg::ST_CHANGED;
                end else begin
                  fin_status <= fwt_pkg::ST_NOSLOT;
                  ctl.mode   <= fwt_pkg::MODE_WAIT;
                end
              end
              fwt_pkg::OP_WAKE: begin
                if (item.addr != '0) begin
                  fin_status <= fwt_pkg::ST_NONE;
                  ctl.mode   <= fwt_pkg::MODE_WAKE;
                end
              end
              fwt_pkg::OP_TICK: begin
                ctl.mode <= fwt_pkg::MODE_TICK;
                ctl.now  <= ctl.now + 1'b1;
              end
              default: begin
                fin_status <= fwt_pkg::ST_INVALID;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (shift) begin
            if (hit) begin
              pend_valid <= 1'b1;
              ctl.n      <= ctl.n + 1'b1;
              ctl.placed <= 1'b1;
            end
            if (step == fwt_pkg::SLOT_W'(fwt_pkg::SLOTS - 1)) begin
              state <= S_FIN;
            end
            step <= step + 1'b1;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state      <= S_IDLE;
            pend_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && shift && hit) begin
      pend <= head_res;
    end
    if (out_load) begin
      result <= out_data;
    end
  end

endmodule
